>>> rtl/ier_pkg.sv
// shared types and constants of the icmp echo reply builder
// no dependencies; imported by ier_ctrl, ier_dpath and the top level
`default_nettype none
package ier_pkg;

   localparam int MAX_FRAME_BYTES = 2048;
   localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 256);
   localparam int SUM_W = ADDR_W + 16;

   localparam int LINK_W = 7;
   localparam int IP_ADDR_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int IPV4_HDR_BYTES = 20;
   localparam int MIN_IP_ICMP_BYTES = 28;
   localparam int IPV4_PROTO_OFFSET = 9;
   localparam int ICMP_CSUM_BYTES = 4;

   localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
   localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

   localparam logic [LINK_W-1:0] LINK_HDR_RESET = 7'd16;
   localparam logic [IP_ADDR_W-1:0] SRC_ADDR_RESET = 32'h0102_0304;
   localparam logic [IP_ADDR_W-1:0] DST_ADDR_RESET = 32'h0A09_0006;

   localparam logic [CSR_IDX_W-1:0] CSR_LINK_HDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ADDR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DST_ADDR = 2'd2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   typedef enum logic [2:0] {
      STATUS_READY = 3'd0,
      STATUS_NOT_ECHO = 3'd1,
      STATUS_TOO_SHORT = 3'd2,
      STATUS_TOO_LONG = 3'd3,
      STATUS_NOTHING = 3'd4
   } ier_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PROTO,
      ST_TYPE,
      ST_FOLD,
      ST_PULL,
      ST_RESP
   } ier_state_type;

   typedef struct packed {
      logic push_en;
      logic pull_miss;
      logic pull_load;
      logic rd_proto;
      logic rd_type;
      logic cap_proto;
      logic end_status;
      ier_status_type status;
      logic pad;
      logic fold;
      logic finish;
   } ier_cmd_type;

   typedef struct packed {
      logic too_long;
      logic too_short;
      logic not_echo;
      logic fold_more;
      logic pull_ok;
   } ier_stat_type;

endpackage
`default_nettype wire

>>> rtl/ier_req_if.sv
// request channel: frame byte push or reply byte pull
// depends on nothing beyond the logic type
`default_nettype none
interface ier_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [7:0] frame_byte;
   logic frame_last;

   modport source (output valid, output operation, output frame_byte, output frame_last,
                   input ready);
   modport sink (input valid, input operation, input frame_byte, input frame_last,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/ier_rsp_if.sv
// result channel: frame status or reply byte
// depends on nothing beyond the logic type
`default_nettype none
interface ier_rsp_if;
   logic valid;
   logic ready;
   logic result_kind;
   logic [2:0] frame_status;
   logic [7:0] reply_byte;
   logic reply_last;

   modport source (output valid, output result_kind, output frame_status,
                   output reply_byte, output reply_last, input ready);
   modport sink (input valid, input result_kind, input frame_status,
                 input reply_byte, input reply_last, output ready);
endinterface
`default_nettype wire

>>> rtl/ier_csr_if.sv
// configuration write channel: register index and write data
// widths follow ier_pkg
`default_nettype none
interface ier_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ier_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module ier_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/ier_ctrl.sv
// controller state machine: sequences push, end of frame checks and pulls
// depends on ier_pkg
`default_nettype none
module ier_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_operation,
   input wire logic req_frame_last,
   output logic req_ready,
   output logic rsp_valid,
   input wire logic rsp_ready,
   input wire ier_pkg::ier_stat_type stat,
   output ier_pkg::ier_cmd_type cmd
);
   import ier_pkg::*;

   ier_state_type st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_PULL) begin
                  st_in = stat.pull_ok ? ST_PULL : ST_RESP;
               end else if (req_frame_last) begin
                  st_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            st_in = (stat.too_long || stat.too_short) ? ST_RESP : ST_PROTO;
         end
         ST_PROTO: st_in = ST_TYPE;
         ST_TYPE: begin
            st_in = stat.not_echo ? ST_RESP : ST_FOLD;
         end
         ST_FOLD: begin
            if (!stat.fold_more) begin
               st_in = ST_RESP;
            end
         end
         ST_PULL: st_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = STATUS_READY;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_PULL) begin
                  cmd.pull_miss = !stat.pull_ok;
               end else begin
                  cmd.push_en = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (stat.too_long) begin
               cmd.end_status = 1'b1;
               cmd.status = STATUS_TOO_LONG;
            end else if (stat.too_short) begin
               cmd.end_status = 1'b1;
               cmd.status = STATUS_TOO_SHORT;
            end else begin
               cmd.rd_proto = 1'b1;
            end
         end
         ST_PROTO: begin
            cmd.cap_proto = 1'b1;
            cmd.rd_type = 1'b1;
         end
         ST_TYPE: begin
            if (stat.not_echo) begin
               cmd.end_status = 1'b1;
               cmd.status = STATUS_NOT_ECHO;
            end else begin
               cmd.pad = 1'b1;
            end
         end
         ST_FOLD: begin
            cmd.fold = stat.fold_more;
            cmd.finish = !stat.fold_more;
         end
         ST_PULL: cmd.pull_load = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire

>>> rtl/ier_dpath.sv
// datapath: configuration, frame store, checksum, reply and result registers
// depends on ier_pkg and ier_ram
`default_nettype none
module ier_dpath (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_valid,
   input wire logic [ier_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [ier_pkg::CSR_DATA_W-1:0] csr_data,
   input wire logic [7:0] req_frame_byte,
   input wire ier_pkg::ier_cmd_type cmd,
   output ier_pkg::ier_stat_type stat,
   output logic rsp_result_kind,
   output logic [2:0] rsp_frame_status,
   output logic [7:0] rsp_reply_byte,
   output logic rsp_reply_last
);
   import ier_pkg::*;

   logic [LINK_W-1:0] link_ff, link_in;
   logic [IP_ADDR_W-1:0] src_ff, src_in;
   logic [IP_ADDR_W-1:0] dst_ff, dst_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [7:0] odd_ff, odd_in;
   logic [15:0] csum_ff, csum_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic ready_ff, ready_in;
   logic [7:0] proto_ff, proto_in;
   logic kind_ff, kind_in;
   ier_status_type status_ff, status_in;
   logic [7:0] byte_ff, byte_in;
   logic last_ff, last_in;

   logic [POS_W-1:0] link_ext;
   logic [POS_W-1:0] count_ext;
   logic [POS_W-1:0] icmp_start;
   logic [POS_W-1:0] rel_pos;
   logic [POS_W-1:0] pull_pos;
   logic [POS_W-1:0] rd_pos;
   logic wr_en;
   logic [7:0] rd_data;
   logic [7:0] csum_byte;
   logic [7:0] pull_byte;
   logic [CNT_W-1:0] ptr_next;

   function automatic logic [7:0] addr_byte(input logic [IP_ADDR_W-1:0] addr,
                                            input logic [1:0] sel);
      logic [7:0] b;
      case (sel)
         2'd0: b = addr[31:24];
         2'd1: b = addr[23:16];
         2'd2: b = addr[15:8];
         2'd3: b = addr[7:0];
         default: b = addr[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [CNT_W-1:0] ptr_add1(input logic [CNT_W-1:0] v);
      return v + CNT_W'(1);
   endfunction

   assign link_ext = POS_W'(link_ff);
   assign count_ext = POS_W'(count_ff);
   assign icmp_start = link_ext + POS_W'(IPV4_HDR_BYTES);
   assign rel_pos = count_ext - icmp_start;
   assign pull_pos = link_ext + POS_W'(ptr_ff);
   assign ptr_next = ptr_ff + CNT_W'(1);

   always_comb begin
      if (cmd.rd_proto) begin
         rd_pos = link_ext + POS_W'(IPV4_PROTO_OFFSET);
      end else if (cmd.rd_type) begin
         rd_pos = icmp_start;
      end else begin
         rd_pos = pull_pos;
      end
   end

   assign wr_en = cmd.push_en && (count_ff < CNT_W'(MAX_FRAME_BYTES));

   ier_ram #(
      .WIDTH(8),
      .DEPTH(MAX_FRAME_BYTES)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(req_frame_byte),
      .rd_addr(rd_pos[ADDR_W-1:0]),
      .rd_data(rd_data)
   );

   assign csum_byte = (rel_pos < POS_W'(ICMP_CSUM_BYTES)) ? 8'h00 : req_frame_byte;

   always_comb begin
      stat.too_long = count_ff > CNT_W'(MAX_FRAME_BYTES);
      stat.too_short = count_ext < link_ext + POS_W'(MIN_IP_ICMP_BYTES);
      stat.not_echo = (proto_ff != IP_PROTO_ICMP) || (rd_data != ICMP_ECHO_REQUEST);
      stat.fold_more = |sum_ff[SUM_W-1:16];
      stat.pull_ok = ready_ff && (ptr_ff < len_ff);
   end

   always_comb begin
      pull_byte = (pull_pos < POS_W'(MAX_FRAME_BYTES)) ? rd_data : 8'h00;
      if (ptr_ff >= CNT_W'(12) && ptr_ff < CNT_W'(16)) begin
         pull_byte = addr_byte(src_ff, ptr_ff[1:0]);
      end else if (ptr_ff >= CNT_W'(16) && ptr_ff < CNT_W'(20)) begin
         pull_byte = addr_byte(dst_ff, ptr_ff[1:0]);
      end else if (ptr_ff == CNT_W'(20) || ptr_ff == CNT_W'(21)) begin
         pull_byte = 8'h00;
      end else if (ptr_ff == CNT_W'(22)) begin
         pull_byte = csum_ff[15:8];
      end else if (ptr_ff == CNT_W'(23)) begin
         pull_byte = csum_ff[7:0];
      end
   end

   always_comb begin
      link_in = link_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      odd_in = odd_ff;
      csum_in = csum_ff;
      len_in = len_ff;
      ptr_in = ptr_ff;
      ready_in = ready_ff;
      proto_in = proto_ff;
      kind_in = kind_ff;
      status_in = status_ff;
      byte_in = byte_ff;
      last_in = last_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_LINK_HDR: link_in = csr_data[LINK_W-1:0];
            CSR_SRC_ADDR: src_in = csr_data;
            CSR_DST_ADDR: dst_in = csr_data;
            default: begin
            end
         endcase
      end

      if (cmd.push_en) begin
         ready_in = 1'b0;
         if (count_ff < CNT_W'(MAX_FRAME_BYTES)) begin
            count_in = ptr_add1(count_ff);
            if (count_ext >= icmp_start) begin
               if (!rel_pos[0]) begin
                  odd_in = csum_byte;
               end else begin
                  sum_in = sum_ff + SUM_W'({odd_ff, csum_byte});
               end
            end
         end else begin
            count_in = CNT_W'(MAX_FRAME_BYTES + 1);
         end
      end

      if (cmd.pull_miss) begin
         ready_in = 1'b0;
         kind_in = KIND_BYTE;
         status_in = STATUS_NOTHING;
         byte_in = 8'h00;
         last_in = 1'b0;
      end

      if (cmd.pull_load) begin
         kind_in = KIND_BYTE;
         status_in = STATUS_READY;
         byte_in = pull_byte;
         last_in = (ptr_next == len_ff);
         if (ptr_next == len_ff) begin
            ready_in = 1'b0;
         end
         ptr_in = ptr_next;
      end

      if (cmd.cap_proto) begin
         proto_in = rd_data;
      end

      if (cmd.pad && (count_ff[0] ^ link_ff[0])) begin
         sum_in = sum_ff + SUM_W'({odd_ff, 8'h00});
      end

      if (cmd.fold) begin
         sum_in = SUM_W'(sum_ff[15:0]) + (sum_ff >> 16);
      end

      if (cmd.finish) begin
         csum_in = ~sum_ff[15:0];
         len_in = count_ff - CNT_W'(link_ff);
         ptr_in = '0;
         ready_in = 1'b1;
      end

      if (cmd.end_status || cmd.finish) begin
         kind_in = KIND_STATUS;
         status_in = cmd.finish ? STATUS_READY : cmd.status;
         byte_in = 8'h00;
         last_in = 1'b0;
         count_in = '0;
         sum_in = '0;
         odd_in = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= LINK_HDR_RESET;
         src_ff <= SRC_ADDR_RESET;
         dst_ff <= DST_ADDR_RESET;
         count_ff <= '0;
         sum_ff <= '0;
         odd_ff <= 8'h00;
         csum_ff <= 16'h0000;
         len_ff <= '0;
         ptr_ff <= '0;
         ready_ff <= 1'b0;
      end else begin
         link_ff <= link_in;
         src_ff <= src_in;
         dst_ff <= dst_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         odd_ff <= odd_in;
         csum_ff <= csum_in;
         len_ff <= len_in;
         ptr_ff <= ptr_in;
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      proto_ff <= proto_in;
      kind_ff <= kind_in;
      status_ff <= status_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_result_kind = kind_ff;
   assign rsp_frame_status = status_ff;
   assign rsp_reply_byte = byte_ff;
   assign rsp_reply_last = last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME_BYTES + 1))
      else $error("byte count beyond saturation");

   a_ready_ptr: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (ptr_ff < len_ff))
      else $error("reply pending with pointer past its end");

   a_push_cancels: assert property (@(posedge clock) disable iff (reset)
      cmd.push_en |=> !ready_ff)
      else $error("reply still pending after a push");
endmodule
`default_nettype wire

>>> rtl/icmp_echo_reply_builder.sv
// top level of the icmp echo reply builder
// depends on ier_pkg, the ier channel interfaces, ier_ctrl and ier_dpath
//
// A frame is pushed one byte per request (operation 0): a push without the last
// flag gives no result, the ICMP checksum being summed as the bytes arrive. The
// status result of the last push is offered after a step of length checks, two
// frame store reads for the protocol and type bytes, then end-around carry
// folding and checksum forming; a failed check ends the sequence early. A pull
// (operation 1) result is read through the registered read port of the frame
// store, a step skipped when no reply is pending. One request is handled at a
// time: the next is taken once the result of the previous has been taken on the
// result channel. Configuration writes are always ready and take effect at once;
// the frame store needs no clearing after reset.
`default_nettype none
module icmp_echo_reply_builder (
   input wire logic clock,
   input wire logic reset,
   ier_req_if.sink req_chan,
   ier_rsp_if.source rsp_chan,
   ier_csr_if.sink csr_chan
);
   import ier_pkg::*;

   ier_cmd_type cmd;
   ier_stat_type stat;
   logic req_ready;
   logic rsp_valid;

   ier_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_chan.valid),
      .req_operation(req_chan.operation),
      .req_frame_last(req_chan.frame_last),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_chan.ready),
      .stat(stat),
      .cmd(cmd)
   );

   ier_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_chan.valid),
      .csr_index(csr_chan.index),
      .csr_data(csr_chan.data),
      .req_frame_byte(req_chan.frame_byte),
      .cmd(cmd),
      .stat(stat),
      .rsp_result_kind(rsp_chan.result_kind),
      .rsp_frame_status(rsp_chan.frame_status),
      .rsp_reply_byte(rsp_chan.reply_byte),
      .rsp_reply_last(rsp_chan.reply_last)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;
   assign csr_chan.ready = 1'b1;
endmodule
`default_nettype wire
